[rtl/ps2mct_pkg.sv]
// Shared types and constants for the PS/2 mouse packet cursor tracker.
// No dependencies; used by ps2mct_pkt_asm, ps2mct_cursor and the top-level unit.
package ps2mct_pkg;

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    localparam int BOUND_W   = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOUND_X = 2'd0,
        CFG_BOUND_Y = 2'd1
    } cfg_idx_t;

    localparam logic [BOUND_W-1:0] BOUND_X_DFLT = 13'd800;
    localparam logic [BOUND_W-1:0] BOUND_Y_DFLT = 13'd600;

    localparam int POS_X_START = 400;
    localparam int POS_Y_START = 300;

    // Flag byte bit positions
    localparam int FLAG_LEFT   = 0;
    localparam int FLAG_RIGHT  = 1;
    localparam int FLAG_MIDDLE = 2;
    localparam int FLAG_SYNC   = 3;
    localparam int FLAG_XSIGN  = 4;
    localparam int FLAG_YSIGN  = 5;
    localparam int FLAG_XOVF   = 6;
    localparam int FLAG_YOVF   = 7;

    // Position of the next byte within a packet
    typedef enum logic [1:0] {
        PH_FLAG = 2'd0,
        PH_XDAT = 2'd1,
        PH_YDAT = 2'd2
    } phase_t;

    // Complete packet handed from the assembler to the cursor update
    typedef struct packed {
        logic       valid;
        logic [7:0] flag;
        logic [7:0] x_byte;
        logic [7:0] y_byte;
    } pkt_t;

endpackage

[rtl/ps2mct_pkt_asm.sv]
// Packet assembler: tracks the byte phase and collects flag and X bytes.
// Depends on ps2mct_pkg. Emits a complete non-overflow packet for one cycle.
module ps2mct_pkt_asm (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,       // aux byte is processed this cycle
    input  logic [7:0]        data,
    output ps2mct_pkg::pkt_t  pkt
);

    ps2mct_pkg::phase_t phase_reg, phase_next;
    logic [7:0] flag_reg;
    logic [7:0] xbyte_reg;

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (step) begin
            unique case (phase_reg)
                ps2mct_pkg::PH_FLAG: begin
                    if (data[ps2mct_pkg::FLAG_SYNC]) begin
                        phase_next = ps2mct_pkg::PH_XDAT;
                    end
                end
                ps2mct_pkg::PH_XDAT: phase_next = ps2mct_pkg::PH_YDAT;
                ps2mct_pkg::PH_YDAT: phase_next = ps2mct_pkg::PH_FLAG;
                default:             phase_next = ps2mct_pkg::PH_FLAG;
            endcase
        end
    end

    // Packet output: third byte completes it, overflow packets are dropped
    always_comb begin
        pkt.valid  = 1'b0;
        pkt.flag   = flag_reg;
        pkt.x_byte = xbyte_reg;
        pkt.y_byte = data;
        unique case (phase_reg)
            ps2mct_pkg::PH_YDAT: begin
                pkt.valid = step && !flag_reg[ps2mct_pkg::FLAG_XOVF]
                                 && !flag_reg[ps2mct_pkg::FLAG_YOVF];
            end
            default: pkt.valid = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ps2mct_pkg::PH_FLAG;
            flag_reg  <= 8'd0;
            xbyte_reg <= 8'd0;
        end else begin
            phase_reg <= phase_next;
            if (step && phase_reg == ps2mct_pkg::PH_FLAG && data[ps2mct_pkg::FLAG_SYNC]) begin
                flag_reg <= data;
            end
            if (step && phase_reg == ps2mct_pkg::PH_XDAT) begin
                xbyte_reg <= data;
            end
        end
    end

endmodule

[rtl/ps2mct_cursor.sv]
// Cursor update: applies packet deltas, clamps to the screen bounds.
// Depends on ps2mct_pkg. Holds the cursor position registers.
module ps2mct_cursor #(
    parameter int COORD_BITS = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ps2mct_pkg::pkt_t                    pkt,
    input  logic [ps2mct_pkg::BOUND_W-1:0]      bound_x,
    input  logic [ps2mct_pkg::BOUND_W-1:0]      bound_y,
    output logic [COORD_BITS-1:0]               pos_x_next,
    output logic [COORD_BITS-1:0]               pos_y_next
);

    localparam int LIMIT  = 1 << COORD_BITS;
    localparam int EXT_W  = (ps2mct_pkg::BOUND_W > COORD_BITS + 1) ?
                            ps2mct_pkg::BOUND_W : COORD_BITS + 1;
    localparam int SUM_W  = COORD_BITS + 2;
    localparam int X_RST  = (ps2mct_pkg::POS_X_START > LIMIT - 1) ?
                            LIMIT - 1 : ps2mct_pkg::POS_X_START;
    localparam int Y_RST  = (ps2mct_pkg::POS_Y_START > LIMIT - 1) ?
                            LIMIT - 1 : ps2mct_pkg::POS_Y_START;
    localparam logic [EXT_W-1:0] LIMIT_EXT = EXT_W'(LIMIT);

    logic [COORD_BITS-1:0] pos_x_reg, pos_y_reg;
    logic [COORD_BITS:0]   eff_x, eff_y;
    logic signed [9:0]     dx, neg_dy;
    logic signed [SUM_W-1:0] sum_x, sum_y;

    // Zero bound falls back to the default, large bound saturates
    function automatic logic [COORD_BITS:0] eff_bound(
        input logic [ps2mct_pkg::BOUND_W-1:0] b,
        input logic [ps2mct_pkg::BOUND_W-1:0] dflt
    );
        logic [EXT_W-1:0] v;
        v = (b == '0) ? EXT_W'(dflt) : EXT_W'(b);
        if (v > LIMIT_EXT) begin
            v = LIMIT_EXT;
        end
        return v[COORD_BITS:0];
    endfunction

    // Clamp a moved coordinate to 0..bound-1
    function automatic logic [COORD_BITS-1:0] clamp(
        input logic signed [SUM_W-1:0] s,
        input logic [COORD_BITS:0]     bound
    );
        logic [COORD_BITS:0] bm1;
        bm1 = bound - 1'b1;
        if (s[SUM_W-1]) begin
            return '0;
        end else if (s[COORD_BITS:0] >= bound) begin
            return bm1[COORD_BITS-1:0];
        end else begin
            return s[COORD_BITS-1:0];
        end
    endfunction

    assign eff_x = eff_bound(bound_x, ps2mct_pkg::BOUND_X_DFLT);
    assign eff_y = eff_bound(bound_y, ps2mct_pkg::BOUND_Y_DFLT);

    // 9-bit deltas with sign bits from the flag byte; y is inverted
    assign dx     = 10'(signed'({pkt.flag[ps2mct_pkg::FLAG_XSIGN], pkt.x_byte}));
    assign neg_dy = -10'(signed'({pkt.flag[ps2mct_pkg::FLAG_YSIGN], pkt.y_byte}));

    assign sum_x = signed'({2'b00, pos_x_reg}) + SUM_W'(dx);
    assign sum_y = signed'({2'b00, pos_y_reg}) + SUM_W'(neg_dy);

    assign pos_x_next = clamp(sum_x, eff_x);
    assign pos_y_next = clamp(sum_y, eff_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= COORD_BITS'(X_RST);
            pos_y_reg <= COORD_BITS'(Y_RST);
        end else if (pkt.valid) begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

endmodule

[rtl/ps2_mouse_packet_cursor_tracker_unit.sv]
// PS/2 mouse packet cursor tracker: takes one controller byte word per cycle
// and returns a cursor/button word for each complete, valid 3-byte packet.
// Throughput is one input word per cycle while s_tready is high. The word
// that completes a packet is held in the input register; its result word is
// loaded into the result register once that register is free, and m_tvalid
// is driven from the result register. The only stall source is the result
// register: s_tready drops when that register is full, not being taken, and
// an input word waits.
// Depends on ps2mct_pkg, ps2mct_pkt_asm and ps2mct_cursor.
module ps2_mouse_packet_cursor_tracker_unit #(
    parameter int  COORD_BITS = 12,
    localparam int TDATA_W    = ((2 * COORD_BITS + 3 + 7) / 8) * 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ps2mct_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ps2mct_pkg::BOUND_W-1:0]       cfg_data,
    // Input bytes
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] data_byte
    input  logic                                 s_tuser,   // [0] from_aux
    // Results
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [TDATA_W-1:0]                   m_tdata    // cursor_x, cursor_y,
                                                            // left, right, middle
);

    localparam int PAY_W = 2 * COORD_BITS + 3;

    logic [ps2mct_pkg::BOUND_W-1:0] bound_x_reg, bound_y_reg;
    logic                           in_valid_reg;
    logic [7:0]                     in_data_reg;
    logic                           in_aux_reg;
    logic                           advance;
    logic                           step;
    ps2mct_pkg::pkt_t               pkt;
    logic [COORD_BITS-1:0]          pos_x_next, pos_y_next;
    logic                           out_valid_reg;
    logic [TDATA_W-1:0]             out_data_reg;
    logic [PAY_W-1:0]               payload;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bound_x_reg <= ps2mct_pkg::BOUND_X_DFLT;
            bound_y_reg <= ps2mct_pkg::BOUND_Y_DFLT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ps2mct_pkg::CFG_BOUND_X: bound_x_reg <= cfg_data;
                ps2mct_pkg::CFG_BOUND_Y: bound_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control: input register moves on when the result slot frees
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance || !in_valid_reg;
    assign step     = in_valid_reg && in_aux_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_aux_reg  <= s_tuser;
        end
    end

    ps2mct_pkt_asm u_asm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .data    (in_data_reg),
        .pkt     (pkt)
    );

    ps2mct_cursor #(
        .COORD_BITS (COORD_BITS)
    ) u_cursor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pkt        (pkt),
        .bound_x    (bound_x_reg),
        .bound_y    (bound_y_reg),
        .pos_x_next (pos_x_next),
        .pos_y_next (pos_y_next)
    );

    // Result register
    assign payload = {pkt.flag[ps2mct_pkg::FLAG_MIDDLE],
                      pkt.flag[ps2mct_pkg::FLAG_RIGHT],
                      pkt.flag[ps2mct_pkg::FLAG_LEFT],
                      pos_y_next, pos_x_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= pkt.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pkt.valid) begin
            out_data_reg <= TDATA_W'(payload);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[rtl/ps2mct_checker.sv]
// Port-level checker for the PS/2 mouse packet cursor tracker.
// No package dependencies; bound to ps2_mouse_packet_cursor_tracker_unit below.
module ps2mct_checker #(
    parameter int TDATA_W = 32
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [TDATA_W-1:0]               m_tdata
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Input only stalls behind a blocked result word
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // A fresh result follows an accepted aux word
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser, 2))
        else $error("result without a completing aux word");

endmodule

bind ps2_mouse_packet_cursor_tracker_unit ps2mct_checker #(
    .TDATA_W (TDATA_W)
) u_ps2mct_checker (.*);
